### hdl/i2cts_pkg.sv
// Package for the I2C register transaction sequencer.
// Holds the transfer structs, sequencer phases, bus commands and status codes.
// No dependencies.
package i2cts_pkg;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_byte;
        logic [7:0] read_count;
        logic [7:0] bus_status;
        logic [7:0] bus_data;
    } req_t;

    typedef struct packed {
        logic [2:0] bus_cmd;
        logic [7:0] bus_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        logic [2:0] error_code;
    } rsp_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_W_START,
        PH_W_SLAW,
        PH_W_REG,
        PH_W_DATA,
        PH_R_START,
        PH_R_SLAW,
        PH_R_REG,
        PH_R_REP,
        PH_R_SLAR,
        PH_R_ACK,
        PH_R_NACK
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [6:0] device;
        logic [7:0] register;
        logic [7:0] write_data;
        logic [7:0] bytes_left;
    } seq_state_t;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;

    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_SEND      = 3'd2;
    localparam logic [2:0] CMD_RECV_ACK  = 3'd3;
    localparam logic [2:0] CMD_RECV_NACK = 3'd4;
    localparam logic [2:0] CMD_STOP      = 3'd5;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_START     = 3'd1;
    localparam logic [2:0] ERR_SLAW      = 3'd2;
    localparam logic [2:0] ERR_REG       = 3'd3;
    localparam logic [2:0] ERR_REP_DATA  = 3'd4;
    localparam logic [2:0] ERR_SLAR      = 3'd5;
    localparam logic [2:0] ERR_ACK_READ  = 3'd6;
    localparam logic [2:0] ERR_NACK_READ = 3'd7;

    localparam logic [7:0] STATUS_MASK     = 8'hF8;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_REP_START    = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

    localparam logic [7:0] MASK_RESET = 8'h80;

endpackage

### hdl/i2cts_step.sv
// Next-state and result logic of the I2C register transaction sequencer.
// One request in, the updated sequencer state and at most one response out.
// Depends on i2cts_pkg.
module i2cts_step (
    input  logic                   valid,
    input  i2cts_pkg::req_t        req,
    input  i2cts_pkg::seq_state_t  cur,
    input  logic [7:0]             addr_mask,
    output i2cts_pkg::seq_state_t  nxt,
    output logic                   rsp_valid,
    output i2cts_pkg::rsp_t        rsp
);
    import i2cts_pkg::*;

    logic [7:0] status;
    logic [7:0] sla;
    logic [7:0] count;
    logic [7:0] left_dec;

    assign status   = req.bus_status & STATUS_MASK;
    assign sla      = {cur.device, 1'b0};
    assign count    = (req.read_count == 8'd0) ? 8'd1 : req.read_count;
    assign left_dec = (cur.bytes_left != 8'd0) ? cur.bytes_left - 8'd1 : cur.bytes_left;

    always_comb
    begin
        nxt       = cur;
        rsp_valid = 1'b0;
        rsp       = '0;
        if (valid)
        begin
            if (req.action == ACT_WRITE || req.action == ACT_READ)
            begin
                if (cur.phase == PH_IDLE)
                begin
                    nxt.device     = req.dev_addr;
                    nxt.register   = req.reg_addr;
                    nxt.write_data = req.write_byte;
                    if (req.action == ACT_READ)
                    begin
                        nxt.bytes_left = count;
                        if (count > 8'd1)
                        begin
                            nxt.register = req.reg_addr | addr_mask;
                        end
                        nxt.phase = PH_R_START;
                    end
                    else
                    begin
                        nxt.phase = PH_W_START;
                    end
                    rsp_valid   = 1'b1;
                    rsp.bus_cmd = CMD_START;
                end
            end
            else if (req.action == ACT_STEP && cur.phase != PH_IDLE)
            begin
                rsp_valid = 1'b1;
                case (cur.phase)
                    PH_W_START, PH_R_START:
                    begin
                        if (status != ST_START)
                        begin
                            rsp.error_code = ERR_START;
                        end
                        else
                        begin
                            nxt.phase    = (cur.phase == PH_W_START) ? PH_W_SLAW : PH_R_SLAW;
                            rsp.bus_cmd  = CMD_SEND;
                            rsp.bus_byte = sla;
                        end
                    end
                    PH_W_SLAW, PH_R_SLAW:
                    begin
                        if (status != ST_MT_SLA_ACK)
                        begin
                            rsp.error_code = ERR_SLAW;
                        end
                        else
                        begin
                            nxt.phase    = (cur.phase == PH_W_SLAW) ? PH_W_REG : PH_R_REG;
                            rsp.bus_cmd  = CMD_SEND;
                            rsp.bus_byte = cur.register;
                        end
                    end
                    PH_W_REG:
                    begin
                        if (status != ST_MT_DATA_ACK)
                        begin
                            rsp.error_code = ERR_REG;
                        end
                        else
                        begin
                            nxt.phase    = PH_W_DATA;
                            rsp.bus_cmd  = CMD_SEND;
                            rsp.bus_byte = cur.write_data;
                        end
                    end
                    PH_W_DATA:
                    begin
                        if (status != ST_MT_DATA_ACK)
                        begin
                            rsp.error_code = ERR_REP_DATA;
                        end
                        else
                        begin
                            nxt.phase    = PH_IDLE;
                            rsp.bus_cmd  = CMD_STOP;
                            rsp.done_res = 1'b1;
                        end
                    end
                    PH_R_REG:
                    begin
                        if (status != ST_MT_DATA_ACK)
                        begin
                            rsp.error_code = ERR_REG;
                        end
                        else
                        begin
                            nxt.phase   = PH_R_REP;
                            rsp.bus_cmd = CMD_START;
                        end
                    end
                    PH_R_REP:
                    begin
                        if (status != ST_REP_START)
                        begin
                            rsp.error_code = ERR_REP_DATA;
                        end
                        else
                        begin
                            nxt.phase    = PH_R_SLAR;
                            rsp.bus_cmd  = CMD_SEND;
                            rsp.bus_byte = sla | 8'd1;
                        end
                    end
                    PH_R_SLAR:
                    begin
                        if (status != ST_MR_SLA_ACK)
                        begin
                            rsp.error_code = ERR_SLAR;
                        end
                        else if (cur.bytes_left > 8'd1)
                        begin
                            nxt.phase   = PH_R_ACK;
                            rsp.bus_cmd = CMD_RECV_ACK;
                        end
                        else
                        begin
                            nxt.phase   = PH_R_NACK;
                            rsp.bus_cmd = CMD_RECV_NACK;
                        end
                    end
                    PH_R_ACK:
                    begin
                        if (status != ST_MR_DATA_ACK)
                        begin
                            rsp.error_code = ERR_ACK_READ;
                        end
                        else
                        begin
                            nxt.bytes_left = left_dec;
                            rsp.read_valid = 1'b1;
                            rsp.read_byte  = req.bus_data;
                            if (left_dec > 8'd1)
                            begin
                                nxt.phase   = PH_R_ACK;
                                rsp.bus_cmd = CMD_RECV_ACK;
                            end
                            else
                            begin
                                nxt.phase   = PH_R_NACK;
                                rsp.bus_cmd = CMD_RECV_NACK;
                            end
                        end
                    end
                    PH_R_NACK:
                    begin
                        if (status != ST_MR_DATA_NACK)
                        begin
                            rsp.error_code = ERR_NACK_READ;
                        end
                        else
                        begin
                            nxt.bytes_left = 8'd0;
                            nxt.phase      = PH_IDLE;
                            rsp.bus_cmd    = CMD_STOP;
                            rsp.read_valid = 1'b1;
                            rsp.read_byte  = req.bus_data;
                            rsp.done_res   = 1'b1;
                        end
                    end
                    default:
                    begin
                        nxt.phase = PH_IDLE;
                        rsp_valid = 1'b0;
                    end
                endcase
                // A failed status check ends the transaction without a stop.
                if (rsp.error_code != ERR_OK)
                begin
                    nxt.phase    = PH_IDLE;
                    rsp.done_res = 1'b1;
                end
            end
        end
    end

endmodule

### hdl/i2c_register_transaction_sequencer.sv
// Top level of the I2C register transaction sequencer.
// Request register, sequencer state, response register and the mask register.
// Depends on i2cts_pkg and i2cts_step.
//
// Usage:
// Requests arrive on req (req_valid / req_stall): start-write, start-read, or a
// bus completion event carrying the engine's status and received byte. Each
// accepted request yields zero or one response on rsp (rsp_valid / rsp_stall)
// with the next bus command, the byte to send, any received byte, and the
// done flag with an error code. Requests that cause no response (a start while
// busy, a completion while idle, an unused action code) are dropped silently.
// A request sits in an input register and its response is registered: the
// request passes the input register, then the response register, before its
// response is offered on rsp.
// One request is taken every cycle as long as the response register is empty
// or being taken in the same cycle; the single response register sets that.
// When the receiver stalls, the response holds and req_stall rises once the
// input register is also full. The cfg channel writes the multi-byte read
// address mask and is always ready; write it only while the block is idle.
// Reset clears the sequencer to idle, empties both registers and sets the
// mask to 0x80.
module i2c_register_transaction_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  i2cts_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output i2cts_pkg::rsp_t  rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data
);
    import i2cts_pkg::*;

    logic        req_vld_reg;
    req_t        req_q_reg;
    seq_state_t  state_reg;
    seq_state_t  state_next;
    logic        rsp_vld_reg;
    rsp_t        rsp_q_reg;
    logic [7:0]  mask_reg;
    logic        advance;
    logic        step_valid;
    rsp_t        step_rsp;

    // The held request moves on when the response register can take a result.
    assign advance   = req_vld_reg && (!rsp_vld_reg || !rsp_stall);
    assign req_stall = req_vld_reg && !advance;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_q_reg;

    i2cts_step u_step (
        .valid     (advance),
        .req       (req_q_reg),
        .cur       (state_reg),
        .addr_mask (mask_reg),
        .nxt       (state_next),
        .rsp_valid (step_valid),
        .rsp       (step_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
            mask_reg    <= MASK_RESET;
            state_reg   <= '{phase: PH_IDLE, device: '0, register: '0,
                             write_data: '0, bytes_left: '0};
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mask_reg <= cfg_data;
            end
            if (!req_stall)
            begin
                req_vld_reg <= req_valid;
            end
            if (advance)
            begin
                state_reg   <= state_next;
                rsp_vld_reg <= step_valid;
            end
            else if (!rsp_stall)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
        begin
            req_q_reg <= req;
        end
        if (advance && step_valid)
        begin
            rsp_q_reg <= step_rsp;
        end
    end

endmodule
